// ===== design/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// Types, the fixed palette and the pairwise distance table of the row fit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

  localparam int NPIX  = 8;
  localparam int NCOL  = 16;
  localparam int NPAIR = 105;
  localparam int DW    = 18;   // one squared color distance
  localparam int CW    = 21;   // sum of eight distances
  localparam int GRP   = 8;
  localparam int NG1   = (NPAIR + GRP - 1) / GRP;
  localparam int NG2   = (NG1 + GRP - 1) / GRP;

  typedef logic [NPIX-1:0][3:0] row_t;
  typedef logic [NCOL-1:0][23:0] pal_t;
  typedef logic [NCOL*NCOL-1:0][DW-1:0] dist_tab_t;
  typedef logic [NPIX-1:0][NCOL-1:0][DW-1:0] drow_t;

  typedef struct packed {
    logic [CW-1:0] cost;
    logic [7:0]    pat;
    logic [7:0]    col;
  } cand_t;

  // entry 15 first
  localparam pal_t PAL = {
    24'hFFFFFF, 24'hCCCCCC, 24'hC95BBA, 24'h21B03B,
    24'hE6CE80, 24'hD4C154, 24'hFF7978, 24'hFC5554,
    24'h42EBF5, 24'hD4524D, 24'h7D76FC, 24'h5455ED,
    24'h5EDC78, 24'h21C842, 24'h000000, 24'h000000
  };

  function automatic logic [DW-1:0] chan_sq(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return DW'(d) * DW'(d);
  endfunction

  function automatic dist_tab_t build_dist();
    dist_tab_t t;
    for (int p = 0; p < NCOL; p++) begin
      for (int q = 0; q < NCOL; q++) begin
        t[p*NCOL+q] = chan_sq(PAL[p][23:16], PAL[q][23:16])
                    + chan_sq(PAL[p][15:8],  PAL[q][15:8])
                    + chan_sq(PAL[p][7:0],   PAL[q][7:0]);
      end
    end
    return t;
  endfunction

  localparam dist_tab_t DIST_TAB = build_dist();

  // color byte {hi, lo} of pair k in search order
  function automatic logic [7:0] pair_col(int k);
    int n;
    logic [7:0] r;
    n = 0;
    r = '0;
    for (int lo = 1; lo < NCOL; lo++) begin
      for (int hi = lo + 1; hi < NCOL; hi++) begin
        if (n == k) r = {4'(hi), 4'(lo)};
        n++;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/tcf_dist.sv =====
// ----------------------------------------------------------------------------
// tcf_dist
// Stage one: distance from every pixel to every palette color.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_dist (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire tcf_pkg::row_t row_i,
  output tcf_pkg::drow_t     drow_o
);

  tcf_pkg::drow_t drow_d, drow_q;

  // table lookup per pixel and color
  always_comb begin
    for (int i = 0; i < tcf_pkg::NPIX; i++) begin
      for (int c = 0; c < tcf_pkg::NCOL; c++) begin
        drow_d[i][c] = tcf_pkg::DIST_TAB[{row_i[i], 4'(c)}];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) drow_q <= drow_d;
  end

  assign drow_o = drow_q;

endmodule

`default_nettype wire

// ===== design/tcf_pair_cost.sv =====
// ----------------------------------------------------------------------------
// tcf_pair_cost
// Stage two: pattern and row cost of every candidate color pair.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_pair_cost (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire tcf_pkg::drow_t drow_i,
  output tcf_pkg::cand_t      cand_o [tcf_pkg::NPAIR]
);

  tcf_pkg::cand_t cand_q [tcf_pkg::NPAIR];

  for (genvar k = 0; k < tcf_pkg::NPAIR; k++) begin : g_pair
    localparam logic [7:0] COL = tcf_pkg::pair_col(k);
    tcf_pkg::cand_t cand_d;

    // per pixel pick the nearer color, then add up as a balanced tree
    always_comb begin
      logic [tcf_pkg::DW-1:0] dlo, dhi;
      logic [tcf_pkg::CW-1:0] pick [tcf_pkg::NPIX];
      cand_d.pat = '0;
      cand_d.col = COL;
      for (int i = 0; i < tcf_pkg::NPIX; i++) begin
        dlo = drow_i[i][COL[3:0]];
        dhi = drow_i[i][COL[7:4]];
        cand_d.pat[tcf_pkg::NPIX-1-i] = (dlo > dhi);
        pick[i] = tcf_pkg::CW'((dlo > dhi) ? dhi : dlo);
      end
      cand_d.cost = ((pick[0] + pick[1]) + (pick[2] + pick[3]))
                  + ((pick[4] + pick[5]) + (pick[6] + pick[7]));
    end

    always_ff @(posedge clk_i) begin
      if (en_i) cand_q[k] <= cand_d;
    end

    assign cand_o[k] = cand_q[k];
  end

endmodule

`default_nettype wire

// ===== design/tcf_min_tree.sv =====
// ----------------------------------------------------------------------------
// tcf_min_tree
// Stages three to five: registered minimum tree, earliest pair wins ties.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_min_tree (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire tcf_pkg::cand_t cand_i [tcf_pkg::NPAIR],
  output tcf_pkg::cand_t      best_o
);

  localparam tcf_pkg::cand_t PAD = '{cost: '1, pat: '0, col: '0};

  tcf_pkg::cand_t l1_d [tcf_pkg::NG1];
  tcf_pkg::cand_t l1_q [tcf_pkg::NG1];
  tcf_pkg::cand_t l2_d [tcf_pkg::NG2];
  tcf_pkg::cand_t l2_q [tcf_pkg::NG2];
  tcf_pkg::cand_t l3_d, l3_q;

  // first level: groups of eight pairs, strict compare keeps the earlier one
  always_comb begin
    for (int g = 0; g < tcf_pkg::NG1; g++) begin
      l1_d[g] = cand_i[g*tcf_pkg::GRP];
      for (int j = 1; j < tcf_pkg::GRP; j++) begin
        if (g*tcf_pkg::GRP + j < tcf_pkg::NPAIR) begin
          if (cand_i[g*tcf_pkg::GRP+j].cost < l1_d[g].cost) begin
            l1_d[g] = cand_i[g*tcf_pkg::GRP+j];
          end
        end
      end
    end
  end

  // second level: groups of eight first-level winners
  always_comb begin
    for (int g = 0; g < tcf_pkg::NG2; g++) begin
      l2_d[g] = PAD;
      for (int j = 0; j < tcf_pkg::GRP; j++) begin
        if (g*tcf_pkg::GRP + j < tcf_pkg::NG1) begin
          if (j == 0 || l1_q[g*tcf_pkg::GRP+j].cost < l2_d[g].cost) begin
            l2_d[g] = l1_q[g*tcf_pkg::GRP+j];
          end
        end
      end
    end
  end

  // last level
  always_comb begin
    l3_d = l2_q[0];
    for (int g = 1; g < tcf_pkg::NG2; g++) begin
      if (l2_q[g].cost < l3_d.cost) l3_d = l2_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l1_q <= l1_d;
      l2_q <= l2_d;
      l3_q <= l3_d;
    end
  end

  assign best_o = l3_q;

endmodule

`default_nettype wire

// ===== design/two_color_line_fit.sv =====
// ----------------------------------------------------------------------------
// two_color_line_fit
// Best two-color fit of one 8-pixel palette row.
// ----------------------------------------------------------------------------
// Each request is one row of eight palette indices; the result is the pattern
// byte and color byte of the cheapest color pair over all 105 pairs. The
// block is a five-stage pipeline (distance lookup, pair cost, three levels of
// minimum tree) and takes one row every cycle while it is not stalled by
// back-pressure. The pipeline advances whenever the output register is empty
// or being taken, so back-pressure stalls all stages.
`default_nettype none

module two_color_line_fit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [3:0] pixel_0_i,
  input  wire logic [3:0] pixel_1_i,
  input  wire logic [3:0] pixel_2_i,
  input  wire logic [3:0] pixel_3_i,
  input  wire logic [3:0] pixel_4_i,
  input  wire logic [3:0] pixel_5_i,
  input  wire logic [3:0] pixel_6_i,
  input  wire logic [3:0] pixel_7_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      pattern_byte_o,
  output logic [7:0]      color_byte_o
);

  localparam int NSTG = 5;

  logic              en;
  logic [NSTG-1:0]   vld_d, vld_q;
  tcf_pkg::row_t     row;
  tcf_pkg::drow_t    drow;
  tcf_pkg::cand_t    cand [tcf_pkg::NPAIR];
  tcf_pkg::cand_t    best;

  assign en  = ~vld_q[NSTG-1] | out_ready_i;
  assign row = {pixel_7_i, pixel_6_i, pixel_5_i, pixel_4_i,
                pixel_3_i, pixel_2_i, pixel_1_i, pixel_0_i};

  // valid bits follow the data
  assign vld_d = {vld_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  tcf_dist u_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .row_i  (row),
    .drow_o (drow)
  );

  tcf_pair_cost u_pair_cost (
    .clk_i  (clk_i),
    .en_i   (en),
    .drow_i (drow),
    .cand_o (cand)
  );

  tcf_min_tree u_min_tree (
    .clk_i  (clk_i),
    .en_i   (en),
    .cand_i (cand),
    .best_o (best)
  );

  assign in_ready_o     = en;
  assign out_valid_o    = vld_q[NSTG-1];
  assign pattern_byte_o = best.pat;
  assign color_byte_o   = best.col;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-color row fit.
// ----------------------------------------------------------------------------
// Rows of palette indices go in through a valid/ready driver fed from a queue.
// A behavioral search over all color pairs predicts each row's pattern and
// color byte, and a monitor compares every result with the oldest prediction.
// Both sides idle in random bursts, except during the last part of the run.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RAND   = 400;
  localparam int CALM_TAIL  = 60;
  localparam int LATENCY    = 5;
  localparam int MAX_CYCLES = 200000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [3:0] pix_drv [tcf_pkg::NPIX];
  logic       out_valid;
  logic       out_ready;
  logic [7:0] pattern_byte;
  logic [7:0] color_byte;

  typedef struct packed {
    logic [7:0] pat;
    logic [7:0] col;
  } fit_t;

  // palette held by the bench, entry 0 first
  logic [23:0] palette [tcf_pkg::NCOL] = '{
    24'h000000, 24'h000000, 24'h21C842, 24'h5EDC78,
    24'h5455ED, 24'h7D76FC, 24'hD4524D, 24'h42EBF5,
    24'hFC5554, 24'hFF7978, 24'hD4C154, 24'hE6CE80,
    24'h21B03B, 24'hC95BBA, 24'hCCCCCC, 24'hFFFFFF
  };

  tcf_pkg::row_t pending_rows [$];
  fit_t          expected_fits [$];
  int            rows_sent;
  int            burst_in;
  int            burst_out;
  int            cycle_cnt;
  bit            failed;
  bit            stim_done;

  two_color_line_fit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .pixel_0_i     (pix_drv[0]),
    .pixel_1_i     (pix_drv[1]),
    .pixel_2_i     (pix_drv[2]),
    .pixel_3_i     (pix_drv[3]),
    .pixel_4_i     (pix_drv[4]),
    .pixel_5_i     (pix_drv[5]),
    .pixel_6_i     (pix_drv[6]),
    .pixel_7_i     (pix_drv[7]),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pattern_byte_o(pattern_byte),
    .color_byte_o  (color_byte)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // squared rgb distance between two palette entries
  function automatic int unsigned rgb_dist(logic [3:0] p, logic [3:0] q);
    int unsigned acc;
    int          d;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      d = int'(palette[p][c*8 +: 8]) - int'(palette[q][c*8 +: 8]);
      acc += d * d;
    end
    return acc;
  endfunction

  // exhaustive pair search, earliest pair wins a tie; row[0] is pixel 0
  function automatic fit_t best_pair_fit(tcf_pkg::row_t row);
    fit_t        best;
    int unsigned best_cost;
    int unsigned cost;
    int unsigned dlo;
    int unsigned dhi;
    logic [7:0]  pat;
    best_cost = 32'hFFFF_FFFF;
    best = '0;
    for (int lo = 1; lo < tcf_pkg::NCOL; lo++) begin
      for (int hi = lo + 1; hi < tcf_pkg::NCOL; hi++) begin
        cost = 0;
        pat = '0;
        for (int i = 0; i < tcf_pkg::NPIX; i++) begin
          dlo = rgb_dist(row[i], 4'(lo));
          dhi = rgb_dist(row[i], 4'(hi));
          pat = {pat[6:0], dlo > dhi};
          cost += (dlo > dhi) ? dhi : dlo;
        end
        if (cost < best_cost) begin
          best_cost = cost;
          best.pat = pat;
          best.col = {4'(hi), 4'(lo)};
        end
      end
    end
    return best;
  endfunction

  function automatic tcf_pkg::row_t random_row();
    tcf_pkg::row_t r;
    int            a;
    int            b;
    // each pixel is color a or color b half of the time, else a random index
    a = $urandom_range(0, 15);
    b = $urandom_range(0, 15);
    for (int i = 0; i < tcf_pkg::NPIX; i++) begin
      case ($urandom_range(0, 3))
        0: r[i] = 4'(a);
        1: r[i] = 4'(b);
        default: r[i] = 4'($urandom_range(0, 15));
      endcase
    end
    return r;
  endfunction

  // stimulus
  initial begin
    tcf_pkg::row_t r;
    for (int k = 0; k < tcf_pkg::NCOL; k++) begin
      pending_rows.push_back({tcf_pkg::NPIX{4'(k)}});
    end
    pending_rows.push_back({4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF});
    pending_rows.push_back({4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0});
    pending_rows.push_back({4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'h8});
    pending_rows.push_back({4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF, 4'h0});
    pending_rows.push_back({4'h6, 4'h8, 4'h9, 4'h6, 4'h8, 4'h9, 4'h6, 4'h8});
    pending_rows.push_back({4'h2, 4'hC, 4'h3, 4'h2, 4'hC, 4'h3, 4'h2, 4'hC});
    for (int k = 0; k < NUM_RAND; k++) begin
      r = random_row();
      pending_rows.push_back(r);
    end
  end

  // reset and cycle limit
  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    cycle_cnt = 0;
    failed = 1'b0;
    stim_done = 1'b0;
    rows_sent = 0;
    burst_in = 0;
    burst_out = 0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    for (int i = 0; i < tcf_pkg::NPIX; i++) pix_drv[i] = '0;
  end

  // driver: request held until accepted
  always @(posedge clk) begin
    tcf_pkg::row_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_fits.push_back(best_pair_fit({pix_drv[7], pix_drv[6], pix_drv[5],
          pix_drv[4], pix_drv[3], pix_drv[2], pix_drv[1], pix_drv[0]}));
        rows_sent <= rows_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (burst_in > 0) begin
          burst_in <= burst_in - 1;
          in_valid <= 1'b0;
        end else if (pending_rows.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          burst_in <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          r = pending_rows.pop_front();
          for (int i = 0; i < tcf_pkg::NPIX; i++) pix_drv[i] <= r[tcf_pkg::NPIX-1-i];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver stalls and result check
  always @(posedge clk) begin
    fit_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_fits.size() == 0) begin
          $display("%0t: unexpected result pattern=%h color=%h",
                   $time, pattern_byte, color_byte);
          failed = 1'b1;
        end else begin
          want = expected_fits.pop_front();
          if (pattern_byte !== want.pat) begin
            $display("%0t: pattern_byte expected %h actual %h",
                     $time, want.pat, pattern_byte);
            failed = 1'b1;
          end
          if (color_byte !== want.col) begin
            $display("%0t: color_byte expected %h actual %h",
                     $time, want.col, color_byte);
            failed = 1'b1;
          end
        end
      end
      if (burst_out > 0) begin
        burst_out <= burst_out - 1;
        out_ready <= 1'b0;
      end else if (pending_rows.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        burst_out <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (expected_fits.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (!failed && expected_fits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/tcf_pkg.sv
design/tcf_dist.sv
design/tcf_pair_cost.sv
design/tcf_min_tree.sv
design/two_color_line_fit.sv
tb/tb_top.sv
